// ===== sv/hps_pkg.sv =====
// hps_pkg: pattern tables, codes and helper functions for the haptic
// pattern sequencer. No dependencies; used by the interfaces and the top level.
package hps_pkg;

    localparam int PAT_SLOTS   = 7;
    localparam int MAX_STEPS   = 6;
    localparam int MS_W        = 10;
    localparam int ELAPSED_W   = 13;
    localparam int DUTY_W      = 8;
    localparam int PAT_W       = 3;
    localparam int STEP_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    typedef logic [MS_W-1:0]      t_ms;
    typedef logic [ELAPSED_W-1:0] t_elapsed;
    typedef logic [DUTY_W-1:0]    t_duty;
    typedef logic [PAT_W-1:0]     t_pat;
    typedef logic [STEP_W-1:0]    t_step;

    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_PLAY = 1'b1
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DUTY_FULL   = 2'd0,
        CFG_DUTY_SOFT   = 2'd1,
        CFG_LOOP_WINDOW = 2'd2
    } t_cfg_idx;

    localparam t_duty    DUTY_FULL_RST   = 8'd255;
    localparam t_duty    DUTY_SOFT_RST   = 8'd128;
    localparam t_elapsed LOOP_WINDOW_RST = 13'd5000;
    localparam t_elapsed ELAPSED_MAX     = 13'd8191;

    localparam t_ms ON_MS [PAT_SLOTS][MAX_STEPS] = '{
        '{10'd150, 10'd150, 10'd150, 10'd0,   10'd0,   10'd0},
        '{10'd500, 10'd200, 10'd0,   10'd0,   10'd0,   10'd0},
        '{10'd150, 10'd150, 10'd0,   10'd0,   10'd0,   10'd0},
        '{10'd250, 10'd250, 10'd250, 10'd0,   10'd0,   10'd0},
        '{10'd200, 10'd200, 10'd200, 10'd200, 10'd0,   10'd0},
        '{10'd80,  10'd80,  10'd80,  10'd80,  10'd80,  10'd600},
        '{10'd100, 10'd100, 10'd350, 10'd0,   10'd0,   10'd0}
    };

    localparam t_ms OFF_MS [PAT_SLOTS][MAX_STEPS] = '{
        '{10'd80,  10'd80,  10'd500, 10'd0,   10'd0,   10'd0},
        '{10'd150, 10'd650, 10'd0,   10'd0,   10'd0,   10'd0},
        '{10'd100, 10'd0,   10'd0,   10'd0,   10'd0,   10'd0},
        '{10'd150, 10'd150, 10'd0,   10'd0,   10'd0,   10'd0},
        '{10'd100, 10'd100, 10'd100, 10'd0,   10'd0,   10'd0},
        '{10'd60,  10'd60,  10'd60,  10'd60,  10'd200, 10'd0},
        '{10'd80,  10'd80,  10'd0,   10'd0,   10'd0,   10'd0}
    };

    localparam t_step STEP_COUNT [PAT_SLOTS] = '{
        3'd3, 3'd2, 3'd2, 3'd3, 3'd4, 3'd6, 3'd3
    };
    localparam logic [PAT_SLOTS-1:0] IS_SOFT = 7'b0001100;  // bit p = pattern p
    localparam logic [PAT_SLOTS-1:0] IS_LOOP = 7'b0000011;

    function automatic t_ms on_ms(input t_pat p, input t_step s);
        t_ms v;
        v = '0;
        if (int'(p) < PAT_SLOTS && int'(s) < MAX_STEPS) begin
            v = ON_MS[p][s];
        end
        return v;
    endfunction

    function automatic t_ms off_ms(input t_pat p, input t_step s);
        t_ms v;
        v = '0;
        if (int'(p) < PAT_SLOTS && int'(s) < MAX_STEPS) begin
            v = OFF_MS[p][s];
        end
        return v;
    endfunction

    function automatic t_step step_count(input t_pat p);
        t_step v;
        v = '0;
        if (int'(p) < PAT_SLOTS) begin
            v = STEP_COUNT[p];
        end
        return v;
    endfunction

    function automatic logic is_soft(input t_pat p);
        logic v;
        v = 1'b0;
        if (int'(p) < PAT_SLOTS) begin
            v = IS_SOFT[p];
        end
        return v;
    endfunction

    function automatic logic is_loop(input t_pat p);
        logic v;
        v = 1'b0;
        if (int'(p) < PAT_SLOTS) begin
            v = IS_LOOP[p];
        end
        return v;
    endfunction

endpackage

// ===== sv/hps_if.sv =====
// Handshake channel interfaces of the haptic pattern sequencer: request,
// result and configuration write. Depends on hps_pkg.
interface hps_req_if;
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    hps_pkg::t_pat        pattern;
    modport source (output valid, output req_type, output pattern, input ready);
    modport sink   (input valid, input req_type, input pattern, output ready);
endinterface

interface hps_res_if;
    logic                 valid;
    logic                 ready;
    hps_pkg::t_duty       duty;
    logic                 busy_res;
    modport source (output valid, output duty, output busy_res, input ready);
    modport sink   (input valid, input duty, input busy_res, output ready);
endinterface

interface hps_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [hps_pkg::CFG_IDX_W-1:0]     index;
    logic [hps_pkg::CFG_DATA_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/haptic_pattern_sequencer.sv =====
// Haptic pattern sequencer top level: timer state, pattern stepping and the
// result register. Depends on hps_pkg and the channels in hps_if.sv.
//
// Usage:
//   i_req carries items: a 1 ms tick (req_type 0) or a play request
//   (req_type 1, pattern id). A play aborts the running pattern; ids at or
//   above NUM_PATTERNS leave the block idle. Every item yields one result on
//   o_res: the motor duty after that item and a busy flag.
//   i_cfg writes duty_full (0), duty_soft (1) and loop_window_ms (2); other
//   indexes are dropped. It is always ready; write only while idle.
//   Latency: the result is valid the cycle after the item is accepted.
//   Throughput: one item per cycle; the state update is a single pass of
//   table lookup and a 10-bit decrement between the state registers.
//   Stall: the result register holds while o_res.ready is low; i_req.ready
//   stays high as long as that register is empty or being drained.
//   Reset (i_rst_n low, synchronous): idle, registers at 255, 128 and 5000,
//   no result pending; the duty and busy result registers are not reset.
module haptic_pattern_sequencer #(
    parameter int NUM_PATTERNS = 7
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hps_req_if.sink   i_req,
    hps_res_if.source o_res,
    hps_cfg_if.sink   i_cfg
);

    // configuration
    hps_pkg::t_duty    r_duty_full;
    hps_pkg::t_duty    r_duty_soft;
    hps_pkg::t_elapsed r_loop_window;

    // sequencer state
    logic              r_active,  n_active;
    hps_pkg::t_pat     r_pat,     n_pat;
    hps_pkg::t_step    r_step,    n_step;
    logic              r_off,     n_off;
    hps_pkg::t_ms      r_rem,     n_rem;
    hps_pkg::t_elapsed r_elapsed, n_elapsed;

    // result register
    logic              r_out_valid;
    hps_pkg::t_duty    r_duty,    n_duty;
    logic              r_busy;

    logic              in_accept;
    hps_pkg::t_step    step_inc;
    hps_pkg::t_ms      rem_dec;
    hps_pkg::t_ms      off_val;
    hps_pkg::t_elapsed elapsed_inc;

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign in_accept   = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid    = r_out_valid;
    assign o_res.duty     = r_duty;
    assign o_res.busy_res = r_busy;

    assign step_inc    = r_step + 3'd1;
    assign rem_dec     = (r_rem != '0) ? r_rem - 10'd1 : '0;
    assign off_val     = hps_pkg::off_ms(r_pat, r_step);
    assign elapsed_inc = (r_elapsed < hps_pkg::ELAPSED_MAX) ? r_elapsed + 13'd1 : r_elapsed;

    always_comb begin
        n_active  = r_active;
        n_pat     = r_pat;
        n_step    = r_step;
        n_off     = r_off;
        n_rem     = r_rem;
        n_elapsed = r_elapsed;
        if (i_req.req_type == hps_pkg::REQ_PLAY) begin
            n_active  = 1'b0;
            n_off     = 1'b0;
            n_rem     = '0;
            n_step    = '0;
            n_elapsed = '0;
            if (int'(i_req.pattern) < NUM_PATTERNS) begin
                n_pat = i_req.pattern;
                // zero window: a looping pattern plays nothing
                if (!(hps_pkg::is_loop(i_req.pattern) && r_loop_window == '0)) begin
                    n_active = 1'b1;
                    n_rem    = hps_pkg::on_ms(i_req.pattern, '0);
                end
            end
        end else if (r_active) begin
            n_elapsed = elapsed_inc;
            n_rem     = rem_dec;
            if (rem_dec == '0) begin
                if (!r_off && off_val != '0) begin
                    n_off = 1'b1;
                    n_rem = off_val;
                end else begin
                    n_step = step_inc;
                    n_off  = 1'b0;
                    if (step_inc >= hps_pkg::step_count(r_pat)) begin
                        if (hps_pkg::is_loop(r_pat) && elapsed_inc < r_loop_window) begin
                            n_step = '0;
                            n_rem  = hps_pkg::on_ms(r_pat, '0);
                        end else begin
                            n_active = 1'b0;
                            n_rem    = '0;
                        end
                    end else begin
                        n_rem = hps_pkg::on_ms(r_pat, step_inc);
                    end
                end
            end
        end
    end

    always_comb begin
        n_duty = '0;
        if (n_active && !n_off) begin
            n_duty = hps_pkg::is_soft(n_pat) ? r_duty_soft : r_duty_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_full   <= hps_pkg::DUTY_FULL_RST;
            r_duty_soft   <= hps_pkg::DUTY_SOFT_RST;
            r_loop_window <= hps_pkg::LOOP_WINDOW_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                hps_pkg::CFG_DUTY_FULL:   r_duty_full   <= i_cfg.data[hps_pkg::DUTY_W-1:0];
                hps_pkg::CFG_DUTY_SOFT:   r_duty_soft   <= i_cfg.data[hps_pkg::DUTY_W-1:0];
                hps_pkg::CFG_LOOP_WINDOW: r_loop_window <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_pat     <= '0;
            r_step    <= '0;
            r_off     <= 1'b0;
            r_rem     <= '0;
            r_elapsed <= '0;
        end else if (in_accept) begin
            r_active  <= n_active;
            r_pat     <= n_pat;
            r_step    <= n_step;
            r_off     <= n_off;
            r_rem     <= n_rem;
            r_elapsed <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_duty <= n_duty;
            r_busy <= n_active;
        end
    end

endmodule
